### rtl/tlvd_pkg.sv
// ----------------------------------------------------------------------------
// tlvd_pkg
// Types and constants shared by the TLV message deframer and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvd_pkg;

  // Record parser phase
  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,  // expect record length byte
    PH_ACT   = 2'd1,  // expect record action byte
    PH_BODY  = 2'd2,  // content byte
    PH_FIRST = 2'd3   // first content byte of a new non-join record
  } phase_t;

  // Result kinds
  localparam logic KIND_CONTENT = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [7:0]  JOIN_RESET  = 8'hFF;
  localparam logic [14:0] REC_CNT_MAX = 15'h7FFF;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [15:0] HDR_BYTES   = 16'd3;

  // Result queue
  localparam int QAW    = 2;
  localparam int QDEPTH = 1 << QAW;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  record_action;
    logic [7:0]  content_byte;
    logic        record_start;
    logic [7:0]  packet_action;
    logic        frame_ok;
    logic [14:0] record_total;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

### rtl/tlvd_in_if.sv
// ----------------------------------------------------------------------------
// tlvd_in_if
// Byte request channel into the deframer: valid/ready plus one frame byte and a frame-end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

`default_nettype wire

### rtl/tlvd_out_if.sv
// ----------------------------------------------------------------------------
// tlvd_out_if
// Result request channel out of the deframer: content bytes and frame status.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlvd_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  record_action;
  logic [7:0]  content_byte;
  logic        record_start;
  logic [7:0]  packet_action;
  logic        frame_ok;
  logic [14:0] record_total;
  logic        last;

  modport source (
    output valid, output out_kind, output record_action, output content_byte,
    output record_start, output packet_action, output frame_ok,
    output record_total, output last, input ready
  );
  modport sink (
    input valid, input out_kind, input record_action, input content_byte,
    input record_start, input packet_action, input frame_ok,
    input record_total, input last, output ready
  );
endinterface

`default_nettype wire

### rtl/tlv_message_deframer.sv
// ----------------------------------------------------------------------------
// tlv_message_deframer
// Splits a length-prefixed frame into tagged content bytes and a frame status.
// ----------------------------------------------------------------------------
// The block takes one frame byte per request on in_chan and can take a new
// byte every cycle while the result queue has room. A byte is held in an
// input register and parsed from there by a single pass of small counter and
// compare logic; its results (none, one, or a content byte followed by a
// frame status) are pushed into a four-entry result queue that drives
// out_chan. Throughput is one byte per cycle while the queue has room; it is
// bounded by the out_chan port, which moves at most one result per cycle, so a
// frame-ending byte that also carries content needs two output results. The
// parser stalls only when the queue holds more than two results.
// cfg_wr_en/cfg_wr_data load the join action code (reset 0xFF); write it only
// while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_message_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  tlvd_in_if.sink         in_chan,
  tlvd_out_if.source      out_chan
);

  localparam int QOW = tlvd_pkg::QAW + 1;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [7:0] join_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      join_code_r <= tlvd_pkg::JOIN_RESET;
    end else if (cfg_wr_en) begin
      join_code_r <= cfg_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_fend_r;
  logic       proc_fire;
  logic       in_take;

  logic [QOW-1:0] occ_r;

  // Parse the held byte only when the queue has room for two results
  assign proc_fire     = in_vld_r && (occ_r <= QOW'(tlvd_pkg::QDEPTH - 2));
  assign in_chan.ready = !in_vld_r || proc_fire;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_chan.data_byte;
      in_fend_r <= in_chan.frame_end;
    end
  end

  // --------------------------------------------------------------------------
  // Frame and record state
  // --------------------------------------------------------------------------
  logic [15:0]      pos_r, pos_nxt;
  logic             ovf_r, ovf_nxt;
  logic [15:0]      hdr_len_r, hdr_len_nxt;
  logic [7:0]       hdr_act_r, hdr_act_nxt;
  logic [15:0]      pl_left_r, pl_left_nxt;
  tlvd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       rec_left_r, rec_left_nxt;
  logic [7:0]       cur_act_r, cur_act_nxt;
  logic             have_rec_r, have_rec_nxt;
  logic             skip_r, skip_nxt;
  logic             halted_r, halted_nxt;
  logic [14:0]      rec_cnt_r, rec_cnt_nxt;

  logic             emit;
  logic             start;
  logic             frame_ok;
  logic [7:0]       rec_left_dec;

  assign rec_left_dec = rec_left_r - 8'd1;

  always_comb begin
    pos_nxt      = pos_r;
    ovf_nxt      = ovf_r;
    hdr_len_nxt  = hdr_len_r;
    hdr_act_nxt  = hdr_act_r;
    pl_left_nxt  = pl_left_r;
    phase_nxt    = phase_r;
    rec_left_nxt = rec_left_r;
    cur_act_nxt  = cur_act_r;
    have_rec_nxt = have_rec_r;
    skip_nxt     = skip_r;
    halted_nxt   = halted_r;
    rec_cnt_nxt  = rec_cnt_r;
    emit         = 1'b0;
    start        = 1'b0;

    // Header bytes: length high, length low, packet action
    if (pos_r == 16'd0) begin
      hdr_len_nxt = {in_byte_r, 8'd0};
    end else if (pos_r == 16'd1) begin
      hdr_len_nxt = {hdr_len_r[15:8], in_byte_r};
    end else if (pos_r == 16'd2) begin
      hdr_act_nxt = in_byte_r;
      pl_left_nxt = (hdr_len_r >= tlvd_pkg::HDR_BYTES) ?
                    hdr_len_r - tlvd_pkg::HDR_BYTES : 16'd0;
    end else if (!halted_r && (pl_left_r != 16'd0)) begin
      case (phase_r)
        tlvd_pkg::PH_LEN: begin
          // Drop into halt on a record too short or past the header length
          if ((in_byte_r <= 8'd2) || ({8'd0, in_byte_r} > pl_left_r)) begin
            halted_nxt = 1'b1;
          end else begin
            rec_left_nxt = in_byte_r - 8'd2;
            phase_nxt    = tlvd_pkg::PH_ACT;
            pl_left_nxt  = pl_left_r - 16'd1;
          end
        end
        tlvd_pkg::PH_ACT: begin
          pl_left_nxt = pl_left_r - 16'd1;
          if (in_byte_r == join_code_r) begin
            // A join with nothing before it is consumed silently
            skip_nxt  = !have_rec_r;
            phase_nxt = tlvd_pkg::PH_BODY;
          end else begin
            cur_act_nxt  = in_byte_r;
            have_rec_nxt = 1'b1;
            skip_nxt     = 1'b0;
            if (rec_cnt_r != tlvd_pkg::REC_CNT_MAX) begin
              rec_cnt_nxt = rec_cnt_r + 15'd1;
            end
            phase_nxt = tlvd_pkg::PH_FIRST;
          end
        end
        default: begin
          start        = (phase_r == tlvd_pkg::PH_FIRST);
          pl_left_nxt  = pl_left_r - 16'd1;
          rec_left_nxt = rec_left_dec;
          phase_nxt    = (rec_left_dec == 8'd0) ? tlvd_pkg::PH_LEN : tlvd_pkg::PH_BODY;
          emit         = !skip_r;
        end
      endcase
    end

    // Count received bytes, saturating
    if (pos_r == tlvd_pkg::POS_MAX) begin
      ovf_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + 16'd1;
    end
  end

  assign frame_ok = (pos_nxt >= tlvd_pkg::HDR_BYTES) && !ovf_nxt &&
                    (pos_nxt == hdr_len_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      ovf_r      <= 1'b0;
      hdr_len_r  <= '0;
      hdr_act_r  <= '0;
      pl_left_r  <= '0;
      phase_r    <= tlvd_pkg::PH_LEN;
      rec_left_r <= '0;
      cur_act_r  <= '0;
      have_rec_r <= 1'b0;
      skip_r     <= 1'b0;
      halted_r   <= 1'b0;
      rec_cnt_r  <= '0;
    end else if (proc_fire) begin
      if (in_fend_r) begin
        // Frame end: return the frame state to reset
        pos_r      <= '0;
        ovf_r      <= 1'b0;
        hdr_len_r  <= '0;
        hdr_act_r  <= '0;
        pl_left_r  <= '0;
        phase_r    <= tlvd_pkg::PH_LEN;
        rec_left_r <= '0;
        cur_act_r  <= '0;
        have_rec_r <= 1'b0;
        skip_r     <= 1'b0;
        halted_r   <= 1'b0;
        rec_cnt_r  <= '0;
      end else begin
        pos_r      <= pos_nxt;
        ovf_r      <= ovf_nxt;
        hdr_len_r  <= hdr_len_nxt;
        hdr_act_r  <= hdr_act_nxt;
        pl_left_r  <= pl_left_nxt;
        phase_r    <= phase_nxt;
        rec_left_r <= rec_left_nxt;
        cur_act_r  <= cur_act_nxt;
        have_rec_r <= have_rec_nxt;
        skip_r     <= skip_nxt;
        halted_r   <= halted_nxt;
        rec_cnt_r  <= rec_cnt_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result build: content result first, status result after it
  // --------------------------------------------------------------------------
  tlvd_pkg::result_t res_content;
  tlvd_pkg::result_t res_status;

  always_comb begin
    res_content.out_kind      = tlvd_pkg::KIND_CONTENT;
    res_content.record_action = cur_act_nxt;
    res_content.content_byte  = in_byte_r;
    res_content.record_start  = start;
    res_content.packet_action = hdr_act_nxt;
    res_content.frame_ok      = 1'b0;
    res_content.record_total  = '0;
    res_content.last          = !in_fend_r;

    res_status.out_kind      = tlvd_pkg::KIND_STATUS;
    res_status.record_action = '0;
    res_status.content_byte  = '0;
    res_status.record_start  = 1'b0;
    res_status.packet_action = hdr_act_nxt;
    res_status.frame_ok      = frame_ok;
    res_status.record_total  = rec_cnt_nxt;
    res_status.last          = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  tlvd_pkg::result_t          q_mem [tlvd_pkg::QDEPTH];
  logic [tlvd_pkg::QAW-1:0]   head_r;
  logic [tlvd_pkg::QAW-1:0]   tail_r;
  logic                       push_first;
  logic                       push_second;
  logic                       pop;
  logic [QOW-1:0]             push_cnt;
  tlvd_pkg::result_t          first_res;

  assign push_first  = proc_fire && (emit || in_fend_r);
  assign push_second = proc_fire && emit && in_fend_r;
  assign first_res   = emit ? res_content : res_status;
  assign push_cnt    = QOW'(push_first) + QOW'(push_second);
  assign pop         = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (push_first) begin
      q_mem[tail_r] <= first_res;
    end
    if (push_second) begin
      q_mem[tail_r + tlvd_pkg::QAW'(1)] <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      occ_r  <= '0;
    end else begin
      tail_r <= tail_r + push_cnt[tlvd_pkg::QAW-1:0];
      if (pop) begin
        head_r <= head_r + tlvd_pkg::QAW'(1);
      end
      occ_r <= occ_r + push_cnt - QOW'(pop);
    end
  end

  tlvd_pkg::result_t head_res;
  assign head_res = q_mem[head_r];

  assign out_chan.valid         = (occ_r != '0);
  assign out_chan.out_kind      = head_res.out_kind;
  assign out_chan.record_action = head_res.record_action;
  assign out_chan.content_byte  = head_res.content_byte;
  assign out_chan.record_start  = head_res.record_start;
  assign out_chan.packet_action = head_res.packet_action;
  assign out_chan.frame_ok      = head_res.frame_ok;
  assign out_chan.record_total  = head_res.record_total;
  assign out_chan.last          = head_res.last;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= QOW'(tlvd_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_fire_room: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire |-> (occ_r <= QOW'(tlvd_pkg::QDEPTH - 2)))
    else $error("byte parsed without room for two results");

  a_halt_phase: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (phase_r == tlvd_pkg::PH_LEN))
    else $error("parser halted outside the length phase");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && in_fend_r) |=> (pos_r == 16'd0) && !have_rec_r)
    else $error("frame state not cleared after frame end");

  a_cnt_have: assert property (@(posedge clk) disable iff (!rst_n)
    !have_rec_r |-> (rec_cnt_r == 15'd0))
    else $error("record count without a record");
`endif

endmodule

`default_nettype wire
